// ===== hw/rtl/ovss_pkg.sv =====
package ovss_pkg;

	localparam int ValueWidth = 32;
	localparam int ReqWidth   = 2;
	localparam int FieldWidth = 7;

	typedef enum logic [ReqWidth-1:0] {
		REQ_INSERT = 2'd0,
		REQ_DELETE = 2'd1,
		REQ_LOOKUP = 2'd2,
		REQ_UNUSED = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_UPD
	} state_t;

	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctl_t;

endpackage

// ===== hw/rtl/ovss_cell.sv =====
module ovss_cell
	import ovss_pkg::*;
(
	input  logic                  clk,
	input  cell_ctl_t             ctl,
	input  logic [ValueWidth-1:0] load_data,
	input  logic [ValueWidth-1:0] shift_data,
	input  logic [ValueWidth-1:0] key,
	input  logic                  occupied,
	output logic [ValueWidth-1:0] data,
	output logic                  match
);

	logic [ValueWidth-1:0] data_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			data_q <= load_data;
		end else if (ctl.shift) begin
			data_q <= shift_data;
		end
	end

	assign data  = data_q;
	assign match = occupied && (data_q == key);

endmodule

// ===== hw/rtl/ordered_value_set_store.sv =====
// channel   | signals                          | direction
// ----------+----------------------------------+----------
// request   | in_valid in_ready req_type value | in
// result    | out_valid out_ready found        | out
//           | position count full_error       |
//
// a request passes a compare state, which compares the key in every cell at
// once and encodes the position, and an update state, which loads or shifts
// cells and fills the result register. a new request is taken in that state.
// reset clears the element count and control; cell contents need no reset.
// a result waiting on out_ready holds the update cycle and stops intake.
module ordered_value_set_store
	import ovss_pkg::*;
#(
	parameter int CAPACITY = 64
)(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [ReqWidth-1:0]          req_type,
	input  logic signed [ValueWidth-1:0] value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         found,
	output logic [FieldWidth-1:0]        position,
	output logic [FieldWidth-1:0]        count,
	output logic                         full_error
);

	localparam int CW = $clog2(CAPACITY + 1);

	state_t state_q, state_d;

	logic [ReqWidth-1:0]   req_s1, req_s2;
	logic [ValueWidth-1:0] value_s1;
	logic                  found_s2;
	logic [CW-1:0]         pos_s2;
	logic [CW-1:0]         elem_count_q;

	logic                  out_valid_q, found_q, full_error_q;
	logic [FieldWidth-1:0] position_q, count_q;

	logic [CAPACITY-1:0]   match;
	logic [ValueWidth-1:0] cell_data [CAPACITY];
	cell_ctl_t             cell_ctl  [CAPACITY];

	logic          accept, fire, any_match, is_full, do_insert, do_delete;
	logic [CW-1:0] pos_enc, pos_d, count_d;

	assign fire     = (state_q == ST_UPD) && (!out_valid_q || out_ready);
	assign in_ready = (state_q == ST_IDLE) || fire;
	assign accept   = in_valid && in_ready;

	// one-hot match: stored values are unique
	always_comb begin
		pos_enc = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (match[i]) begin
				pos_enc = pos_enc | CW'(i);
			end
		end
	end
	assign any_match = |match;

	assign is_full   = (elem_count_q == CW'(CAPACITY));
	assign do_insert = fire && (req_s2 == REQ_INSERT) && !is_full && !found_s2;
	assign do_delete = fire && (req_s2 == REQ_DELETE) && found_s2;
	assign pos_d     = found_s2 ? pos_s2 : elem_count_q;

	always_comb begin
		count_d = elem_count_q;
		if (do_insert) begin
			count_d = elem_count_q + CW'(1);
		end else if (do_delete) begin
			count_d = elem_count_q - CW'(1);
		end
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [ValueWidth-1:0] next_data;
		if (g == CAPACITY - 1) begin : g_last
			assign next_data = cell_data[g];
		end else begin : g_mid
			assign next_data = cell_data[g+1];
		end

		always_comb begin
			cell_ctl[g].load  = do_insert && (elem_count_q == CW'(g));
			cell_ctl[g].shift = do_delete && (CW'(g) >= pos_s2);
		end

		ovss_cell u_cell (
			.clk        (clk),
			.ctl        (cell_ctl[g]),
			.load_data  (value_s1),
			.shift_data (next_data),
			.key        (value_s1),
			.occupied   (CW'(g) < elem_count_q),
			.data       (cell_data[g]),
			.match      (match[g])
		);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				state_d = ST_UPD;
			end
			ST_UPD: begin
				if (fire) begin
					state_d = accept ? ST_CMP : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			elem_count_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			elem_count_q <= count_d;
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request value stays in s1 through the update so an insert can load it
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1   <= req_type;
			value_s1 <= value;
		end
		if (state_q == ST_CMP) begin
			req_s2   <= req_s1;
			found_s2 <= any_match;
			pos_s2   <= pos_enc;
		end
		if (fire) begin
			found_q      <= found_s2;
			position_q   <= FieldWidth'(pos_d);
			count_q      <= FieldWidth'(count_d);
			full_error_q <= (req_s2 == REQ_INSERT) && is_full;
		end
	end

	assign out_valid  = out_valid_q;
	assign found      = found_q;
	assign position   = position_q;
	assign count      = count_q;
	assign full_error = full_error_q;

endmodule

// ===== hw/rtl/ovss_checker.sv =====
module ovss_checker
	import ovss_pkg::*;
#(
	parameter int CAPACITY = 64
)(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic                  found,
	input logic [FieldWidth-1:0] position,
	input logic [FieldWidth-1:0] count,
	input logic                  full_error
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(position) && $stable(count)
			&& $stable(found) && $stable(full_error))
		else $error("stalled result changed");

	// one request in compare at a time
	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken during compare cycle");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && full_error |-> count == FieldWidth'(CAPACITY) && position != count + 7'd1)
		else $error("full error with wrong count");

	// an absent value reports the old count, which grows by at most one
	a_absent_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> (count == position) || (count == position + 7'd1))
		else $error("absent value with inconsistent position");

endmodule

bind ordered_value_set_store ovss_checker #(.CAPACITY(CAPACITY)) u_ovss_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.found      (found),
	.position   (position),
	.count      (count),
	.full_error (full_error)
);

// ===== tb/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ovss_pkg::*;

	localparam int SetCapacity = 64;
	localparam int PoolSize    = 96;
	localparam int RandomItems = 1050;
	localparam int QuietTail   = 150;
	localparam int DrainCycles = 16;

	typedef struct {
		req_type_t   op;
		logic [31:0] v;
	} set_request_t;

	typedef struct {
		logic                  found;
		logic [FieldWidth-1:0] position;
		logic [FieldWidth-1:0] count;
		logic                  full_error;
	} set_result_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         in_ready;
	req_type_t                    req_type = REQ_LOOKUP;
	logic signed [ValueWidth-1:0] value = '0;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	logic                         found;
	logic [FieldWidth-1:0]        position;
	logic [FieldWidth-1:0]        count;
	logic                         full_error;

	set_request_t pending_requests[$];
	set_result_t  expected_results[$];

	logic [31:0] set_members[SetCapacity];
	int          member_count = 0;
	int          op_totals[4] = '{default: 0};
	int          refused_inserts = 0;
	int          peak_members = 0;
	int          results_checked = 0;
	int          failures = 0;
	bit          stim_done = 1'b0;

	logic [31:0] value_pool[PoolSize];

	int drv_gap = 0;
	int drv_cycle = 0;
	bit drv_calm = 1'b0;
	int mon_stall = 0;
	int mon_cycle = 0;
	bit mon_calm = 1'b0;

	ordered_value_set_store #(
		.CAPACITY(SetCapacity)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.found     (found),
		.position  (position),
		.count     (count),
		.full_error(full_error)
	);

	always #2 clk = ~clk;

	task automatic apply_set_request(input req_type_t op, input logic [31:0] v);
		int          idx;
		set_result_t r;
		idx = member_count;
		for (int i = member_count - 1; i >= 0; i--) begin
			if (set_members[i] == v) idx = i;
		end
		r.found      = idx < member_count;
		r.position   = idx[FieldWidth-1:0];
		r.full_error = 1'b0;
		case (op)
			REQ_INSERT: begin
				if (member_count >= SetCapacity) begin
					r.full_error = 1'b1;
					refused_inserts++;
				end else if (!r.found) begin
					set_members[member_count] = v;
					member_count++;
				end
			end
			REQ_DELETE: begin
				if (r.found) begin
					for (int i = idx; i + 1 < member_count; i++) set_members[i] = set_members[i + 1];
					member_count--;
				end
			end
			default: ;
		endcase
		r.count = member_count[FieldWidth-1:0];
		if (member_count > peak_members) peak_members = member_count;
		op_totals[int'(op)]++;
		expected_results.push_back(r);
	endtask

	task automatic add_request(input req_type_t op, input logic [31:0] v);
		set_request_t r;
		r.op = op;
		r.v  = v;
		pending_requests.push_back(r);
	endtask

	function automatic logic [31:0] pick_value();
		if ($urandom_range(0, 6) == 0) return $urandom;
		return value_pool[$urandom_range(0, PoolSize - 1)];
	endfunction

	// request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			drv_cycle++;
			if (drv_cycle % 128 == 0) drv_calm = ($urandom_range(0, 3) == 0);
			if (in_valid && in_ready) apply_set_request(req_type, value);
			if (!in_valid || in_ready) begin
				if (drv_gap > 0) begin
					drv_gap--;
					in_valid <= 1'b0;
				end else if (pending_requests.size() > 0) begin
					set_request_t r;
					r = pending_requests.pop_front();
					in_valid <= 1'b1;
					req_type <= r.op;
					value    <= r.v;
					if (pending_requests.size() > QuietTail && !drv_calm && $urandom_range(0, 5) == 0)
						drv_gap = $urandom_range(1, 14);
				end else begin
					in_valid <= 1'b0;
					stim_done = 1'b1;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			mon_cycle++;
			if (mon_cycle % 128 == 0) mon_calm = ($urandom_range(0, 3) == 0);
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("result with no request outstanding");
					failures++;
				end else begin
					set_result_t e;
					e = expected_results.pop_front();
					results_checked++;
					if (found !== e.found) begin
						$error("found: expected %0d, actual %0d", e.found, found);
						failures++;
					end
					if (position !== e.position) begin
						$error("position: expected %0d, actual %0d", e.position, position);
						failures++;
					end
					if (count !== e.count) begin
						$error("count: expected %0d, actual %0d", e.count, count);
						failures++;
					end
					if (full_error !== e.full_error) begin
						$error("full_error: expected %0d, actual %0d", e.full_error, full_error);
						failures++;
					end
				end
			end
			if (mon_stall > 0) begin
				mon_stall--;
				out_ready <= 1'b0;
			end else if (pending_requests.size() > QuietTail && !mon_calm
					&& $urandom_range(0, 5) == 0) begin
				mon_stall = $urandom_range(1, 14) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		int phase;
		int base;
		int target;

		for (int i = 0; i < PoolSize; i++) value_pool[i] = $urandom;
		value_pool[0] = 32'h8000_0000;
		value_pool[1] = 32'h7fff_ffff;
		value_pool[2] = 32'h0000_0000;
		value_pool[3] = 32'hffff_ffff;

		add_request(REQ_INSERT, 32'h8000_0000);
		add_request(REQ_INSERT, 32'h7fff_ffff);
		add_request(REQ_INSERT, 32'h0000_0000);
		add_request(REQ_INSERT, 32'hffff_ffff);
		add_request(REQ_INSERT, 32'h0000_0001);
		add_request(REQ_INSERT, 32'h0000_0000);
		add_request(REQ_LOOKUP, 32'h7fff_ffff);
		add_request(REQ_LOOKUP, 32'h1234_5678);
		add_request(REQ_UNUSED, 32'h0000_0001);
		add_request(REQ_UNUSED, 32'hdead_beef);
		add_request(REQ_DELETE, 32'h8000_0000);
		add_request(REQ_DELETE, 32'h8000_0001);
		add_request(REQ_DELETE, 32'h0000_0001);
		add_request(REQ_LOOKUP, 32'hffff_ffff);
		add_request(REQ_DELETE, 32'h7fff_ffff);
		add_request(REQ_DELETE, 32'h0000_0000);
		add_request(REQ_DELETE, 32'hffff_ffff);
		add_request(REQ_DELETE, 32'hffff_ffff);
		add_request(REQ_LOOKUP, 32'h0000_0000);
		add_request(REQ_INSERT, 32'h5555_5555);
		add_request(REQ_INSERT, 32'haaaa_aaaa);
		add_request(REQ_LOOKUP, 32'haaaa_aaaa);
		add_request(REQ_DELETE, 32'h5555_5555);
		add_request(REQ_DELETE, 32'haaaa_aaaa);

		target = pending_requests.size() + RandomItems;
		phase = 0;
		while (pending_requests.size() < target) begin
			case (phase)
				// grow to full, then push against the limit
				0: begin
					base = $urandom_range(0, PoolSize - 1);
					for (int k = 0; k < 72; k++) begin
						if ($urandom_range(0, 5) == 0)
							add_request($urandom_range(0, 1) ? REQ_LOOKUP : REQ_DELETE, pick_value());
						else
							add_request(REQ_INSERT, value_pool[(base + k) % PoolSize]);
					end
					for (int k = 0; k < 6; k++) add_request(REQ_INSERT, pick_value());
				end
				// shrink
				1: begin
					for (int k = 0; k < 60; k++) begin
						if ($urandom_range(0, 3) != 0)
							add_request(REQ_DELETE, pick_value());
						else
							add_request($urandom_range(0, 1) ? REQ_LOOKUP : REQ_INSERT, pick_value());
					end
				end
				2: begin
					for (int k = 0; k < 60; k++)
						add_request(req_type_t'($urandom_range(0, 3)), pick_value());
				end
				default: begin
					for (int k = 0; k < 20; k++)
						add_request(req_type_t'($urandom_range(0, 3)), $urandom);
				end
			endcase
			phase = $urandom_range(0, 3);
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		do @(posedge clk); while (!(stim_done && expected_results.size() == 0));
		repeat (DrainCycles) @(posedge clk);

		$display("%0d results checked over %0d inserts, %0d deletes, %0d lookups, %0d unused type",
			results_checked, op_totals[REQ_INSERT], op_totals[REQ_DELETE],
			op_totals[REQ_LOOKUP], op_totals[REQ_UNUSED]);
		$display("occupancy peaked at %0d of %0d, %0d inserts refused while full",
			peak_members, SetCapacity, refused_inserts);
		if (failures == 0 && expected_results.size() == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("tb failed");
		$finish;
	end

endmodule
